>>> src/tps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle pixel shader package
// Shared constants for the shader pipeline and its division unit.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int DEFAULT_MAX_DIM = 4096;

    localparam int QUOT_W = 8;
    localparam int DEFAULT_DEN_W = 2 * ($clog2(DEFAULT_MAX_DIM + 1) + 2) + 1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int DIM_CFG_W   = 13;
    localparam int STRIDE_W    = 15;
    localparam int OFFSET_W    = 26;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE   = 2'd3;

    localparam logic [1:0] FMT_RGB565   = 2'd0;
    localparam logic [1:0] FMT_RGB888   = 2'd1;
    localparam logic [1:0] FMT_ARGB8888 = 2'd2;

    localparam logic [DIM_CFG_W-1:0] RESET_WIDTH  = 13'd1024;
    localparam logic [DIM_CFG_W-1:0] RESET_HEIGHT = 13'd768;
    localparam logic [1:0]           RESET_FORMAT = FMT_ARGB8888;
    localparam logic [STRIDE_W-1:0]  RESET_STRIDE = 15'd4096;

    localparam logic [31:0] BG_COLOR   = 32'hff182028;
    localparam logic [7:0]  ALPHA_FULL = 8'hff;

    // Reciprocals for exact division by five and six of values below 2^19.
    localparam int          RECIP_SHIFT = 24;
    localparam int          RECIP_W     = 22;
    localparam logic [21:0] RECIP5      = 22'd3355444;
    localparam logic [21:0] RECIP6      = 22'd2796203;

endpackage

>>> src/triangle_pixel_shader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle pixel shader
// Gives the frame content and store address of one pixel of a frame holding
// a shaded triangle over a background.
//
// Pixel coordinates enter on the s_ channel and one result leaves on the m_
// channel for every transfer, in order. The pipeline is fourteen stages deep
// and takes one pixel in every cycle unless it is stalled. The depth is set
// by the nine stages of the quotient divider behind the edge functions.
// All stages advance together: when the receiver holds m_ready low with a
// result waiting, the whole pipeline and s_ready stall, and nothing is lost.
// The cfg_ channel writes frame width, height, pixel format and row stride;
// it is always ready. The user must write it only while no pixel is in
// flight; the block does not enforce this. Reset empties the pipeline and
// restores a 1024 by 768 frame at 32bpp with a stride of 4096 bytes.
// ----------------------------------------------------------------------------
module triangle_pixel_shader
    import tps_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [11:0]            s_pixel_x,
    input  logic [11:0]            s_pixel_y,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_in_frame,
    output logic                   m_covered,
    output logic [31:0]            m_argb_color,
    output logic [31:0]            m_packed_pixel,
    output logic [2:0]             m_byte_count,
    output logic [OFFSET_W-1:0]    m_byte_offset
);

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = DW + 2;
    localparam int PW    = 2 * CW;
    localparam int EW    = PW + 1;
    localparam int MW    = DW + 3 + RECIP_W;
    localparam int DLY   = QUOT_W + 1;
    localparam int LAT   = DLY + 5;

    typedef struct packed {
        logic                inf;
        logic [1:0]          fmt;
        logic [OFFSET_W-1:0] offset;
    } ctl_t;

    typedef struct packed {
        ctl_t ctl;
        logic cov;
    } dctl_t;

    logic [DIM_CFG_W-1:0] width_reg, height_reg;
    logic [1:0]           format_reg;
    logic [STRIDE_W-1:0]  stride_reg;
    logic [LAT-1:0]       valid_reg;
    logic                 advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            format_reg <= RESET_FORMAT;
            stride_reg <= RESET_STRIDE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[DIM_CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[DIM_CFG_W-1:0];
                REG_PIXEL_FORMAT: format_reg <= cfg_data[1:0];
                REG_ROW_STRIDE:   stride_reg <= cfg_data[STRIDE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign advance = !valid_reg[LAT-1] || m_ready;
    assign s_ready = advance;
    assign m_valid = valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    // Stage 0: capture the pixel and the saturated frame size.
    logic [DW-1:0]       w_sat, h_sat;
    logic [11:0]         x0_reg, y0_reg;
    logic [DW-1:0]       w0_reg, h0_reg;
    logic                inf0_reg;
    logic [1:0]          fmt0_reg;
    logic [STRIDE_W-1:0] stride0_reg;

    assign w_sat = (width_reg > MAX_DIM) ? DW'(MAX_DIM) : DW'(width_reg);
    assign h_sat = (height_reg > MAX_DIM) ? DW'(MAX_DIM) : DW'(height_reg);

    always_ff @(posedge aclk) begin
        if (advance) begin
            x0_reg      <= s_pixel_x;
            y0_reg      <= s_pixel_y;
            w0_reg      <= w_sat;
            h0_reg      <= h_sat;
            inf0_reg    <= (s_pixel_x < w_sat) && (s_pixel_y < h_sat);
            fmt0_reg    <= format_reg;
            stride0_reg <= stride_reg;
        end
    end

    // Stage 1: triangle vertices and store address.
    logic [MW-1:0]       bx_prod, cx_prod, ay_prod, by_prod;
    logic [2:0]          bytes0;
    logic [26:0]         row_off;
    logic [13:0]         col_off;
    logic [DW-1:0]       ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg;
    logic [DW-1:0]       x1_reg, y1_reg;
    ctl_t                ctl1_reg;

    always_comb begin
        bx_prod = MW'(w0_reg) * MW'(RECIP5);
        cx_prod = MW'({w0_reg, 2'b00}) * MW'(RECIP5);
        ay_prod = MW'(h0_reg) * MW'(RECIP6);
        by_prod = MW'(MW'(h0_reg) * MW'(5)) * MW'(RECIP6);
        case (fmt0_reg)
            FMT_RGB565: bytes0 = 3'd2;
            FMT_RGB888: bytes0 = 3'd3;
            default:    bytes0 = 3'd4;
        endcase
        row_off = 27'(y0_reg) * 27'(stride0_reg);
        col_off = 14'(x0_reg) * 14'(bytes0);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ax1_reg         <= w0_reg >> 1;
            bx1_reg         <= bx_prod[RECIP_SHIFT +: DW];
            cx1_reg         <= cx_prod[RECIP_SHIFT +: DW];
            ay1_reg         <= ay_prod[RECIP_SHIFT +: DW];
            by1_reg         <= by_prod[RECIP_SHIFT +: DW];
            x1_reg          <= DW'(x0_reg);
            y1_reg          <= DW'(y0_reg);
            ctl1_reg.inf    <= inf0_reg;
            ctl1_reg.fmt    <= fmt0_reg;
            ctl1_reg.offset <= OFFSET_W'(row_off) + OFFSET_W'(col_off);
        end
    end

    // Stage 2: edge function products.
    logic signed [CW-1:0] sax, say, sbx, sby, scx, spx, spy;
    logic signed [PW-1:0] ta0_reg, ta1_reg, t00_reg, t01_reg;
    logic signed [PW-1:0] t10_reg, t11_reg, t20_reg, t21_reg;
    ctl_t                 ctl2_reg;

    assign sax = signed'(CW'(ax1_reg));
    assign say = signed'(CW'(ay1_reg));
    assign sbx = signed'(CW'(bx1_reg));
    assign sby = signed'(CW'(by1_reg));
    assign scx = signed'(CW'(cx1_reg));
    assign spx = signed'(CW'(x1_reg));
    assign spy = signed'(CW'(y1_reg));

    always_ff @(posedge aclk) begin
        if (advance) begin
            ta0_reg  <= PW'(scx - sax) * PW'(sby - say);
            ta1_reg  <= PW'(sby - say) * PW'(sbx - sax);
            t00_reg  <= PW'(spx - sbx) * PW'(sby - sby);
            t01_reg  <= PW'(spy - sby) * PW'(scx - sbx);
            t10_reg  <= PW'(spx - scx) * PW'(say - sby);
            t11_reg  <= PW'(spy - sby) * PW'(sax - scx);
            t20_reg  <= PW'(spx - sax) * PW'(sby - say);
            t21_reg  <= PW'(spy - say) * PW'(sbx - sax);
            ctl2_reg <= ctl1_reg;
        end
    end

    // Stage 3: edge function values.
    logic signed [EW-1:0] area3_reg, e03_reg, e13_reg, e23_reg;
    ctl_t                 ctl3_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            area3_reg <= EW'(ta0_reg) - EW'(ta1_reg);
            e03_reg   <= EW'(t00_reg) - EW'(t01_reg);
            e13_reg   <= EW'(t10_reg) - EW'(t11_reg);
            e23_reg   <= EW'(t20_reg) - EW'(t21_reg);
            ctl3_reg  <= ctl2_reg;
        end
    end

    // Coverage test and dividend set-up feeding the divider pipeline.
    logic                     cov3, all_pos, all_neg;
    logic [EW-1:0]            abs_area, abs0, abs1, abs2;
    logic [EW+QUOT_W-1:0]     num0, num1, num2;
    logic [QUOT_W-1:0]        q0, q1, q2;
    dctl_t                    dl_reg [0:DLY-1];

    always_comb begin
        all_pos  = !e03_reg[EW-1] && !e13_reg[EW-1] && !e23_reg[EW-1];
        all_neg  = (e03_reg[EW-1] || e03_reg == 0) && (e13_reg[EW-1] || e13_reg == 0)
                && (e23_reg[EW-1] || e23_reg == 0);
        cov3     = (area3_reg != 0) && (all_pos || all_neg);
        abs_area = area3_reg[EW-1] ? EW'(-area3_reg) : EW'(area3_reg);
        abs0     = e03_reg[EW-1] ? EW'(-e03_reg) : EW'(e03_reg);
        abs1     = e13_reg[EW-1] ? EW'(-e13_reg) : EW'(e13_reg);
        abs2     = e23_reg[EW-1] ? EW'(-e23_reg) : EW'(e23_reg);
        num0     = {abs0, {QUOT_W{1'b0}}} - (EW+QUOT_W)'(abs0);
        num1     = {abs1, {QUOT_W{1'b0}}} - (EW+QUOT_W)'(abs1);
        num2     = {abs2, {QUOT_W{1'b0}}} - (EW+QUOT_W)'(abs2);
    end

    tps_div #(.DEN_W(EW)) u_div_r (
        .aclk (aclk), .en (advance), .num (num0), .den (abs_area), .quot (q0)
    );
    tps_div #(.DEN_W(EW)) u_div_g (
        .aclk (aclk), .en (advance), .num (num1), .den (abs_area), .quot (q1)
    );
    tps_div #(.DEN_W(EW)) u_div_b (
        .aclk (aclk), .en (advance), .num (num2), .den (abs_area), .quot (q2)
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            dl_reg[0].ctl <= ctl3_reg;
            dl_reg[0].cov <= cov3;
            for (int i = 1; i < DLY; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    // Output stage: colour selection and packing.
    logic [31:0] color;
    logic [31:0] packed_next;
    logic [2:0]  bytes_next;
    dctl_t       last;

    always_comb begin
        last  = dl_reg[DLY-1];
        color = last.cov ? {ALPHA_FULL, q0, q1, q2} : BG_COLOR;
        case (last.ctl.fmt)
            FMT_RGB565: begin
                packed_next = {16'd0, color[23:19], color[15:10], color[7:3]};
                bytes_next  = 3'd2;
            end
            FMT_RGB888: begin
                packed_next = {8'd0, color[23:0]};
                bytes_next  = 3'd3;
            end
            default: begin
                packed_next = color;
                bytes_next  = 3'd4;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_in_frame     <= last.ctl.inf;
            m_covered      <= last.ctl.inf && last.cov;
            m_argb_color   <= last.ctl.inf ? color : 32'd0;
            m_packed_pixel <= last.ctl.inf ? packed_next : 32'd0;
            m_byte_count   <= last.ctl.inf ? bytes_next : 3'd0;
            m_byte_offset  <= last.ctl.inf ? last.ctl.offset : '0;
        end
    end

endmodule

>>> src/tps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle pixel shader divider
// Pipelined restoring divider giving an eight-bit quotient, one bit a stage.
// ----------------------------------------------------------------------------
module tps_div
    import tps_pkg::*;
#(
    parameter int DEN_W = DEFAULT_DEN_W
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [DEN_W+QUOT_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic [QUOT_W-1:0]       quot
);

    localparam int NUM_W = DEN_W + QUOT_W;

    logic [NUM_W-1:0]  rem_reg   [0:QUOT_W-1];
    logic [DEN_W-1:0]  den_reg   [0:QUOT_W-1];
    logic [QUOT_W-1:0] quot_reg  [0:QUOT_W];
    logic [NUM_W-1:0]  trial     [0:QUOT_W-1];
    logic [NUM_W-1:0]  rem_next  [0:QUOT_W-1];
    logic              bit_next  [0:QUOT_W-1];

    always_comb begin
        for (int i = 0; i < QUOT_W; i++) begin
            trial[i]    = NUM_W'(den_reg[i]) << (QUOT_W - 1 - i);
            bit_next[i] = rem_reg[i] >= trial[i];
            rem_next[i] = bit_next[i] ? rem_reg[i] - trial[i] : rem_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            for (int i = 0; i < QUOT_W; i++) begin
                quot_reg[i+1] <= quot_reg[i]
                               | (QUOT_W'(bit_next[i]) << (QUOT_W - 1 - i));
                if (i < QUOT_W - 1) begin
                    rem_reg[i+1] <= rem_next[i];
                    den_reg[i+1] <= den_reg[i];
                end
            end
        end
    end

    assign quot = quot_reg[QUOT_W];

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle pixel shader testbench
// Streams pixel coordinates through the shader under several frame settings
// and checks every result against a behavioural prediction of the coverage
// test, the barycentric colour, the packing and the store offset.
// ----------------------------------------------------------------------------
module tb_top;
    import tps_pkg::*;

    typedef struct packed {
        logic        in_frame;
        logic        covered;
        logic [31:0] argb;
        logic [31:0] pix_word;
        logic [2:0]  nbytes;
        logic [25:0] offset;
    } shade_t;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
    } coord_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [11:0]            s_pixel_x = '0;
    logic [11:0]            s_pixel_y = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_in_frame;
    logic                   m_covered;
    logic [31:0]            m_argb_color;
    logic [31:0]            m_packed_pixel;
    logic [2:0]             m_byte_count;
    logic [OFFSET_W-1:0]    m_byte_offset;

    logic [DIM_CFG_W-1:0] frame_w = RESET_WIDTH;
    logic [DIM_CFG_W-1:0] frame_h = RESET_HEIGHT;
    logic [1:0]           fmt = RESET_FORMAT;
    logic [STRIDE_W-1:0]  stride = RESET_STRIDE;

    coord_t pixel_queue[$];
    shade_t pending_shades[$];
    int     mismatches = 0;
    int     phase = 0;
    bit     quiet = 1'b0;
    bit     hold_done = 1'b0;
    int     send_gap = 0;
    int     recv_stall = 0;
    int     dead_cycles = 0;

    triangle_pixel_shader dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_x(s_pixel_x), .s_pixel_y(s_pixel_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_in_frame(m_in_frame), .m_covered(m_covered),
        .m_argb_color(m_argb_color), .m_packed_pixel(m_packed_pixel),
        .m_byte_count(m_byte_count), .m_byte_offset(m_byte_offset)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
        return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic shade_t shade_pixel(logic [11:0] x, logic [11:0] y);
        shade_t res;
        longint w, h, ax, ay, bx, by, cx, cy, area, e0, e1, e2, a;
        logic [31:0] col;
        logic [7:0] r, g, b;
        res = '0;
        w = frame_w > 4096 ? 4096 : frame_w;
        h = frame_h > 4096 ? 4096 : frame_h;
        if (x >= w || y >= h) begin
            return res;
        end
        ax = w / 2;
        ay = h / 6;
        bx = w / 5;
        by = (h * 5) / 6;
        cx = (w * 4) / 5;
        cy = by;
        area = edge_val(ax, ay, bx, by, cx, cy);
        col = BG_COLOR;
        if (area != 0) begin
            e0 = edge_val(bx, by, cx, cy, x, y);
            e1 = edge_val(cx, cy, ax, ay, x, y);
            e2 = edge_val(ax, ay, bx, by, x, y);
            if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0)) begin
                a = mag(area);
                r = 8'((mag(e0) * 255) / a);
                g = 8'((mag(e1) * 255) / a);
                b = 8'((mag(e2) * 255) / a);
                col = {ALPHA_FULL, r, g, b};
                res.covered = 1'b1;
            end
        end
        res.in_frame = 1'b1;
        res.argb = col;
        if (fmt == FMT_RGB565) begin
            res.pix_word = {16'd0, col[23:19], col[15:10], col[7:3]};
            res.nbytes = 3'd2;
        end else if (fmt == FMT_RGB888) begin
            res.pix_word = {8'd0, col[23:0]};
            res.nbytes = 3'd3;
        end else begin
            res.pix_word = col;
            res.nbytes = 3'd4;
        end
        res.offset = 26'(longint'(y) * stride + longint'(x) * res.nbytes);
        return res;
    endfunction

    // Sender: one item per transfer, the prediction taken at acceptance.
    always @(posedge aclk) begin
        coord_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_shades.push_back(shade_pixel(s_pixel_x, s_pixel_y));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    nxt = pixel_queue.pop_front();
                    s_valid <= 1'b1;
                    s_pixel_x <= nxt.x;
                    s_pixel_y <= nxt.y;
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 19);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each transfer against the oldest prediction.
    always @(posedge aclk) begin
        shade_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_in_frame, m_covered, m_argb_color, m_packed_pixel,
                       m_byte_count, m_byte_offset};
                if (pending_shades.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result %h", got);
                    end
                end else begin
                    want = pending_shades.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected %h got %h", want, got);
                        end
                    end
                end
            end
            if (phase == 2 && !hold_done) begin
                hold_done = 1'b1;
                recv_stall = 300;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(1, 19);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            dead_cycles <= 0;
        end else if (dead_cycles >= 5000) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  frame_w = val[DIM_CFG_W-1:0];
            REG_FRAME_HEIGHT: frame_h = val[DIM_CFG_W-1:0];
            REG_PIXEL_FORMAT: fmt = val[1:0];
            default:          stride = val;
        endcase
    endtask

    task automatic drain();
        while (pixel_queue.size() > 0 || pending_shades.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic add_pixel(int x, int y);
        coord_t c;
        c.x = 12'(x);
        c.y = 12'(y);
        pixel_queue.push_back(c);
    endtask

    task automatic add_random(int count);
        int w, h;
        w = frame_w > 4096 ? 4096 : frame_w;
        h = frame_h > 4096 ? 4096 : frame_h;
        repeat (count) begin
            if (w > 0 && h > 0 && $urandom_range(0, 4) != 0) begin
                add_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
            end else begin
                add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        int w, h;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: vertices, frame centre, frame edges and the extremes.
        w = 1024;
        h = 768;
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(w - 1, h - 1);
        add_pixel(w, 0);
        add_pixel(0, h);
        add_pixel(w / 2, h / 6);
        add_pixel(w / 5, 5 * h / 6);
        add_pixel(4 * w / 5, 5 * h / 6);
        add_pixel(w / 2, h / 2);
        add_pixel(w / 2, 5 * h / 6 + 1);
        add_pixel(w / 2, h / 6 - 1);
        add_random(90);
        drain();

        phase = 1;
        write_reg(REG_PIXEL_FORMAT, FMT_RGB565);
        write_reg(REG_ROW_STRIDE, 15'd2048);
        add_random(100);
        drain();

        phase = 2;
        write_reg(REG_FRAME_WIDTH, 15'd16);
        write_reg(REG_FRAME_HEIGHT, 15'd12);
        write_reg(REG_PIXEL_FORMAT, FMT_RGB888);
        write_reg(REG_ROW_STRIDE, 15'd1);
        add_random(120);
        drain();

        // Oversized frame and the widest stride, with the unused format code.
        phase = 3;
        write_reg(REG_FRAME_WIDTH, 15'd8191);
        write_reg(REG_FRAME_HEIGHT, 15'd8191);
        write_reg(REG_PIXEL_FORMAT, 15'd3);
        write_reg(REG_ROW_STRIDE, 15'd32767);
        add_pixel(4095, 4095);
        add_pixel(2048, 2048);
        add_random(50);
        while (pixel_queue.size() > 0 || pending_shades.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
        add_random(50);
        drain();

        // Degenerate triangle in a one-pixel frame, then zero width.
        phase = 4;
        write_reg(REG_FRAME_WIDTH, 15'd1);
        write_reg(REG_FRAME_HEIGHT, 15'd1);
        write_reg(REG_PIXEL_FORMAT, FMT_ARGB8888);
        add_pixel(0, 0);
        add_random(30);
        drain();
        write_reg(REG_FRAME_WIDTH, 15'd0);
        add_random(30);
        drain();

        phase = 5;
        write_reg(REG_FRAME_WIDTH, 15'd4096);
        write_reg(REG_FRAME_HEIGHT, 15'd4096);
        write_reg(REG_ROW_STRIDE, 15'd16384);
        add_random(120);
        drain();

        phase = 6;
        write_reg(REG_FRAME_WIDTH, 15'($urandom_range(1, 200)));
        write_reg(REG_FRAME_HEIGHT, 15'($urandom_range(1, 200)));
        write_reg(REG_PIXEL_FORMAT, FMT_RGB565);
        write_reg(REG_ROW_STRIDE, 15'($urandom_range(1, 16384)));
        add_random(120);
        drain();

        phase = 7;
        quiet = 1'b1;
        write_reg(REG_FRAME_WIDTH, 15'd640);
        write_reg(REG_FRAME_HEIGHT, 15'd480);
        add_random(120);
        drain();

        mismatches += pending_shades.size();
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
src/tps_pkg.sv
src/tps_div.sv
src/triangle_pixel_shader.sv
tb/tb_top.sv
